// ===== design/bll_pkg.sv =====
// ----------------------------------------------------------------------------
// bll_pkg - shared definitions for the binary-lifting LCA unit
// Node and depth widths, table size, request codes and level defaults.
// ----------------------------------------------------------------------------
package bll_pkg;

  localparam int NODE_W     = 10;
  localparam int NODES      = 1 << NODE_W;
  localparam int LEVELS_DEF = 10;

  typedef logic [NODE_W-1:0] node_t;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

// ===== design/binary_lifting_lca_unit.sv =====
// ----------------------------------------------------------------------------
// binary_lifting_lca_unit - lowest common ancestor by binary lifting
// Stores a rooted tree as a depth table and an ancestor table (row k of a
// node holds its ancestor 2^k steps up) and answers ancestor queries.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in_     | input     | in_valid / in_stall | in_req_type, in_node,
//          |           |                     | in_other_node
//  out_    | output    | out_valid/out_stall | out_ancestor, out_level
//
//  One transaction at a time; in_stall is low only when the sequencer is idle.
//  Add: one dependent ancestor read per level.
//  Query: the depth lift visits each level once and the common lift takes
//  two reads per level through the single table port.
//  The tables need no clearing after reset: reads of node 0 return zero.
//  A finished result waits in the output register while out_stall is high,
//  and the next transaction may start behind it.
module binary_lifting_lca_unit #(
  parameter int LEVELS = bll_pkg::LEVELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  bll_pkg::node_t      in_node,
  input  bll_pkg::node_t      in_other_node,
  output logic                out_valid,
  input  logic                out_stall,
  output bll_pkg::node_t      out_ancestor,
  output bll_pkg::node_t      out_level
);
  import bll_pkg::*;

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [LW-1:0] K_TOP = LW'(LEVELS - 1);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_ADD_DEP  = 12'b0000_0000_0010,
    S_ADD_LIFT = 12'b0000_0000_0100,
    S_Q_DA     = 12'b0000_0000_1000,
    S_Q_DB     = 12'b0000_0001_0000,
    S_Q_LIFT   = 12'b0000_0010_0000,
    S_Q_CHK    = 12'b0000_0100_0000,
    S_Q_RB     = 12'b0000_1000_0000,
    S_Q_CMP    = 12'b0001_0000_0000,
    S_Q_RES    = 12'b0010_0000_0000,
    S_Q_LVL    = 12'b0100_0000_0000,
    S_FIN      = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  node_t             a_r, a_nxt;
  node_t             b_r, b_nxt;
  node_t             res_r, res_nxt;
  node_t             lvl_r, lvl_nxt;
  node_t             da_r, da_nxt;
  node_t             ua_r, ua_nxt;
  logic [LEVELS-1:0] diff_r, diff_nxt;
  logic [LW-1:0]     k_r, k_nxt;
  logic              pend_r, pend_nxt;

  node_t             out_ancestor_r;
  node_t             out_level_r;
  logic              out_valid_r;
  logic              out_load;

  // Table storage
  node_t             dep_mem [NODES];
  node_t             anc_mem [LEVELS][NODES];

  logic              dep_we;
  node_t             dep_wa, dep_wd, dep_ra;
  node_t             dep_rd_r;
  logic              dep_z_r;

  logic              anc_we;
  node_t             anc_wn, anc_wd, anc_rn;
  logic [LW-1:0]     anc_wl, anc_rl;
  node_t             anc_rd_r;
  logic              anc_z_r;

  node_t             dep_q, anc_q, a_cur, a_sel, dep_inc, diff10;
  logic              in_acc;

  // Node 0 is never written, so its entries read as zero by forcing.
  assign dep_q   = dep_z_r ? '0 : dep_rd_r;
  assign anc_q   = anc_z_r ? '0 : anc_rd_r;
  assign a_cur   = pend_r ? anc_q : a_r;
  assign a_sel   = (ua_r != anc_q) ? ua_r : a_r;
  assign dep_inc = (&dep_q) ? dep_q : dep_q + NODE_W'(1);
  assign diff10  = (da_r < dep_q) ? (dep_q - da_r) : (da_r - dep_q);

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    lvl_nxt   = lvl_r;
    da_nxt    = da_r;
    ua_nxt    = ua_r;
    diff_nxt  = diff_r;
    k_nxt     = k_r;
    pend_nxt  = pend_r;
    dep_we    = 1'b0;
    dep_wa    = a_r;
    dep_wd    = dep_inc;
    dep_ra    = '0;
    anc_we    = 1'b0;
    anc_wn    = a_r;
    anc_wl    = k_r;
    anc_wd    = anc_q;
    anc_rn    = '0;
    anc_rl    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          a_nxt = in_node;
          b_nxt = in_other_node;
          if (in_req_type == REQ_ADD) begin
            if (in_node == '0) begin
              res_nxt   = '0;
              lvl_nxt   = '0;
              state_nxt = S_FIN;
            end else begin
              anc_we    = 1'b1;
              anc_wn    = in_node;
              anc_wl    = '0;
              anc_wd    = in_other_node;
              dep_ra    = in_other_node;
              res_nxt   = in_node;
              state_nxt = S_ADD_DEP;
            end
          end else begin
            dep_ra    = in_node;
            state_nxt = S_Q_DA;
          end
        end
      end
      S_ADD_DEP: begin
        dep_we  = 1'b1;
        lvl_nxt = dep_inc;
        anc_rn  = b_r;
        anc_rl  = '0;
        k_nxt   = LW'(1);
        if (LEVELS == 1) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_ADD_LIFT;
        end
      end
      S_ADD_LIFT: begin
        // write level k, and fetch the next link in the same cycle
        anc_we = 1'b1;
        anc_rn = anc_q;
        anc_rl = k_r;
        if (k_r == K_TOP) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt = k_r + LW'(1);
        end
      end
      S_Q_DA: begin
        da_nxt    = dep_q;
        dep_ra    = b_r;
        state_nxt = S_Q_DB;
      end
      S_Q_DB: begin
        // put the deeper node in a
        if (da_r < dep_q) begin
          a_nxt = b_r;
          b_nxt = a_r;
        end
        diff_nxt  = LEVELS'(diff10);
        pend_nxt  = 1'b0;
        k_nxt     = K_TOP;
        state_nxt = S_Q_LIFT;
      end
      S_Q_LIFT: begin
        a_nxt    = a_cur;
        pend_nxt = diff_r[k_r];
        anc_rn   = a_cur;
        anc_rl   = k_r;
        if (k_r == '0) begin
          state_nxt = S_Q_CHK;
        end else begin
          k_nxt = k_r - LW'(1);
        end
      end
      S_Q_CHK: begin
        a_nxt    = a_cur;
        pend_nxt = 1'b0;
        if (a_cur == b_r) begin
          res_nxt   = a_cur;
          dep_ra    = a_cur;
          state_nxt = S_Q_LVL;
        end else begin
          anc_rn    = a_cur;
          anc_rl    = K_TOP;
          k_nxt     = K_TOP;
          state_nxt = S_Q_RB;
        end
      end
      S_Q_RB: begin
        ua_nxt    = anc_q;
        anc_rn    = b_r;
        anc_rl    = k_r;
        state_nxt = S_Q_CMP;
      end
      S_Q_CMP: begin
        // advance both only while their ancestors differ
        if (ua_r != anc_q) begin
          a_nxt = ua_r;
          b_nxt = anc_q;
        end
        anc_rn = a_sel;
        if (k_r == '0) begin
          anc_rl    = '0;
          state_nxt = S_Q_RES;
        end else begin
          anc_rl    = k_r - LW'(1);
          k_nxt     = k_r - LW'(1);
          state_nxt = S_Q_RB;
        end
      end
      S_Q_RES: begin
        res_nxt   = anc_q;
        dep_ra    = anc_q;
        state_nxt = S_Q_LVL;
      end
      S_Q_LVL: begin
        lvl_nxt   = dep_q;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Depth table
  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[dep_wa] <= dep_wd;
    end
    dep_rd_r <= dep_mem[dep_ra];
  end

  // Ancestor table, write-first on a clash of addresses
  always_ff @(posedge clk) begin
    if (anc_we) begin
      anc_mem[anc_wl][anc_wn] <= anc_wd;
    end
    if (anc_we && (anc_wl == anc_rl) && (anc_wn == anc_rn)) begin
      anc_rd_r <= anc_wd;
    end else begin
      anc_rd_r <= anc_mem[anc_rl][anc_rn];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      dep_z_r     <= 1'b1;
      anc_z_r     <= 1'b1;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      dep_z_r <= (dep_ra == '0);
      anc_z_r <= (anc_rn == '0);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    res_r  <= res_nxt;
    lvl_r  <= lvl_nxt;
    da_r   <= da_nxt;
    ua_r   <= ua_nxt;
    diff_r <= diff_nxt;
    k_r    <= k_nxt;
    if (out_load) begin
      out_ancestor_r <= res_r;
      out_level_r    <= lvl_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ancestor = out_ancestor_r;
  assign out_level    = out_level_r;

  // Checks
  a_fin_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == S_IDLE) && out_valid_r)
    else $error("finished transaction not moved to the output register");

  a_no_anc_wr_node0: assert property (@(posedge clk) disable iff (!rst_n)
    anc_we |-> (anc_wn != '0))
    else $error("ancestor table written for the sentinel node");

  a_dep_wr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    dep_we |-> (dep_wa != '0) && (dep_wd != '0))
    else $error("depth write to sentinel or with zero depth");

  a_sentinel_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_ancestor_r == '0)) |-> (out_level_r == '0))
    else $error("sentinel result with non-zero level");

endmodule

// ===== tb/lca_answer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_answer_checker - result predictor and comparator for the LCA unit
// Watches both channels, keeps its own copy of the depth and ancestor tables,
// works out the answer for every accepted request and compares each accepted
// result against the oldest outstanding answer.
// ----------------------------------------------------------------------------
module lca_answer_checker #(
  parameter int LEVELS = bll_pkg::LEVELS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  logic           in_req_type,
  input  bll_pkg::node_t in_node,
  input  bll_pkg::node_t in_other_node,
  input  logic           out_valid,
  input  logic           out_stall,
  input  bll_pkg::node_t out_ancestor,
  input  bll_pkg::node_t out_level,
  output int             fail_count,
  output int             pending
);

  import bll_pkg::*;

  localparam node_t DEPTH_MAX = '1;
  localparam int    REPORT_MAX = 10;

  typedef struct packed {
    node_t ancestor;
    node_t level;
  } answer_t;

  answer_t answers_due [$];
  node_t   depth_mem [NODES];
  node_t   jump_mem [NODES][LEVELS];
  int      mismatches = 0;

  // Lift the deeper node to the same depth, then climb both while they differ.
  function automatic node_t common_ancestor(input node_t a, input node_t b);
    node_t              x;
    node_t              y;
    node_t              ux;
    node_t              uy;
    logic [NODE_W-1:0]  diff;
    x = a;
    y = b;
    if (x == y) return x;
    if (depth_mem[x] < depth_mem[y]) begin
      x = b;
      y = a;
    end
    diff = depth_mem[x] - depth_mem[y];
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (k < NODE_W && diff[k]) x = jump_mem[x][k];
    end
    if (x == y) return x;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      ux = jump_mem[x][k];
      uy = jump_mem[y][k];
      if (ux != uy) begin
        x = ux;
        y = uy;
      end
    end
    return jump_mem[x][0];
  endfunction

  function automatic answer_t apply_request(input logic req, input node_t a, input node_t b);
    answer_t ans;
    node_t   d;
    if (req == REQ_ADD) begin
      // the sentinel is never stored
      if (a == '0) return '0;
      d = depth_mem[b];
      depth_mem[a] = (d == DEPTH_MAX) ? DEPTH_MAX : d + 1'b1;
      jump_mem[a][0] = b;
      for (int k = 1; k < LEVELS; k++) jump_mem[a][k] = jump_mem[jump_mem[a][k-1]][k-1];
      ans.ancestor = a;
    end else begin
      ans.ancestor = common_ancestor(a, b);
    end
    ans.level = depth_mem[ans.ancestor];
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      answers_due.delete();
      for (int n = 0; n < NODES; n++) begin
        depth_mem[n] = '0;
        for (int k = 0; k < LEVELS; k++) jump_mem[n][k] = '0;
      end
    end else begin
      // compare first: a result can never belong to a request taken on this edge
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result: ancestor %0d level %0d",
                     $realtime, out_ancestor, out_level);
        end else begin
          want = answers_due.pop_front();
          if (out_ancestor !== want.ancestor || out_level !== want.level) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: result mismatch: expected ancestor %0d level %0d, got ancestor %0d level %0d",
                       $realtime, want.ancestor, want.level, out_ancestor, out_level);
          end
        end
      end
      if (in_valid && !in_stall)
        answers_due.push_back(apply_request(in_req_type, in_node, in_other_node));
    end
    fail_count <= mismatches;
    pending    <= answers_due.size();
  end

endmodule

// ===== tb/binary_lifting_lca_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_lifting_lca_unit_test - testbench for the binary-lifting LCA unit
// Builds trees through add transactions, asks lowest common ancestor queries
// with random idling on both sides, re-parents two nodes back and forth and
// leaves all result checking to lca_answer_checker.
// ----------------------------------------------------------------------------
module binary_lifting_lca_unit_test;

  import bll_pkg::*;

  localparam int    QUIET_LIMIT  = 2000;
  localparam int    RANDOM_ITEMS = 430;
  localparam int    RAMP_STEPS   = 40;
  localparam int    HOLD_OFF     = 300;
  localparam int    DRAIN_CYCLES = 60;
  localparam node_t RAMP_A       = 10'd1021;
  localparam node_t RAMP_B       = 10'd1022;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  logic  in_req_type;
  node_t in_node;
  node_t in_other_node;
  logic  out_valid;
  logic  out_stall;
  node_t out_ancestor;
  node_t out_level;
  int    fail_count;
  int    pending;

  bit    present [NODES];
  node_t live_nodes [$];
  bit    send_quick = 1'b0;
  int    sent = 0;
  int    quiet = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  binary_lifting_lca_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_node       (in_node),
    .in_other_node (in_other_node),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ancestor  (out_ancestor),
    .out_level     (out_level)
  );

  lca_answer_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_node       (in_node),
    .in_other_node (in_other_node),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ancestor  (out_ancestor),
    .out_level     (out_level),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  function automatic node_t any_live_node();
    return live_nodes[$urandom_range(0, live_nodes.size() - 1)];
  endfunction

  // Offer one transaction after a random gap and hold it until taken.
  task automatic send_item(input logic req, input node_t a, input node_t b);
    int gap;
    if (sent % 50 == 0) send_quick = ($urandom_range(0, 2) == 0);
    gap = send_quick ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_node       <= a;
    in_other_node <= b;
    do @(posedge clk); while (in_stall);
    sent++;
    if (req == REQ_ADD && a != '0 && !present[a]) begin
      present[a] = 1'b1;
      live_nodes.push_back(a);
    end
  endtask

  // Result side: random stalls, quick stretches and two long hold-offs.
  initial begin : result_sink
    int wait_cycles;
    int taken;
    bit quick;
    taken = 0;
    quick = 1'b0;
    forever begin
      if (taken % 40 == 0) quick = ($urandom_range(0, 2) == 0);
      wait_cycles = quick ? 0 : $urandom_range(0, 15);
      if (taken == 60 || taken == 400) wait_cycles = HOLD_OFF;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int    roll;
    int    pick;
    node_t child;
    node_t parent;
    node_t qa;
    node_t qb;
    node_t last_child;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_ADD;
    in_node       <= '0;
    in_other_node <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: sentinel, roots, branches, moves, self and descendant parents
    send_item(REQ_ADD,   10'd0,    10'd0);
    send_item(REQ_ADD,   10'd1,    10'd0);
    send_item(REQ_ADD,   10'd2,    10'd1);
    send_item(REQ_ADD,   10'd3,    10'd1);
    send_item(REQ_ADD,   10'd4,    10'd2);
    send_item(REQ_ADD,   10'd1023, 10'd4);
    send_item(REQ_ADD,   10'd512,  10'd3);
    send_item(REQ_QUERY, 10'd1023, 10'd512);
    send_item(REQ_QUERY, 10'd4,    10'd4);
    send_item(REQ_QUERY, 10'd1023, 10'd1);
    send_item(REQ_QUERY, 10'd1,    10'd1023);
    send_item(REQ_QUERY, 10'd0,    10'd1023);
    send_item(REQ_ADD,   10'd5,    10'd0);
    send_item(REQ_QUERY, 10'd5,    10'd1023);
    send_item(REQ_QUERY, 10'd1023, 10'd0);
    send_item(REQ_ADD,   10'd2,    10'd5);
    send_item(REQ_QUERY, 10'd1023, 10'd512);
    send_item(REQ_ADD,   10'd1,    10'd1);
    send_item(REQ_QUERY, 10'd1,    10'd512);
    send_item(REQ_ADD,   10'd3,    10'd512);
    send_item(REQ_QUERY, 10'd512,  10'd3);
    send_item(REQ_ADD,   10'd682,  10'd1023);
    send_item(REQ_ADD,   10'd341,  10'd682);
    send_item(REQ_QUERY, 10'd341,  10'd682);
    last_child = 10'd341;

    // random: mostly tree growth and queries on present nodes, some sentinel noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_item(REQ_ADD, '0, any_live_node());
      end else if (roll < 10) begin
        if ($urandom_range(0, 1) == 0) send_item(REQ_QUERY, '0, any_live_node());
        else send_item(REQ_QUERY, any_live_node(), '0);
      end else if (roll < 55) begin
        if ($urandom_range(0, 9) == 0 || live_nodes.size() >= NODES - 1) begin
          child = any_live_node();
        end else begin
          do child = node_t'($urandom_range(1, NODES - 1)); while (present[child]);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) parent = '0;
        else if (pick < 7) parent = last_child;
        else parent = any_live_node();
        send_item(REQ_ADD, child, parent);
        last_child = child;
      end else begin
        qa = any_live_node();
        qb = ($urandom_range(0, 9) == 0) ? qa : any_live_node();
        send_item(REQ_QUERY, qa, qb);
      end
    end

    // depth ramp: swap two nodes under each other, deepening them each time
    send_item(REQ_ADD, RAMP_A, '0);
    for (int i = 0; i < RAMP_STEPS; i++) begin
      if (i % 2 == 0) send_item(REQ_ADD, RAMP_B, RAMP_A);
      else send_item(REQ_ADD, RAMP_A, RAMP_B);
      if (i % 10 == 9) send_item(REQ_QUERY, RAMP_A, any_live_node());
    end
    send_item(REQ_QUERY, RAMP_A, RAMP_B);
    send_item(REQ_QUERY, any_live_node(), RAMP_B);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== binary_lifting_lca_unit.f =====
design/bll_pkg.sv
design/binary_lifting_lca_unit.sv
tb/lca_answer_checker.sv
tb/binary_lifting_lca_unit_test.sv
